// ===== hdl/stpr_pkg.sv =====
// shared types, constants and helpers for the speaker toggle pcm resampler
// no dependencies; used by every module under hdl
package stpr_pkg;

  localparam int FRAC_BITS_DEF   = 24;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int LEVEL_W = 16;
  localparam int TIME_W  = 32;
  localparam int RATIO_W = 32;
  localparam int RUN_W   = 16;

  localparam logic [RATIO_W-1:0] SPT_RESET     = 32'd189408058;
  localparam logic [RUN_W-1:0]   MAX_RUN_RESET = 16'd4096;

  localparam logic KIND_SET    = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  typedef enum logic {
    CFG_SAMPLES_PER_TICK = 1'b0,
    CFG_MAX_RUN          = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                      kind;
    logic signed [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]         timestamp;
  } in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] sample;
    logic [RUN_W-1:0]          run_length;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic [RATIO_W-1:0] samples_per_tick;
    logic [RUN_W-1:0]   max_run;
  } cfg_t;

  // classified event: set levels are already clamped, toggles resolve later
  typedef struct packed {
    logic                      toggle;
    logic signed [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]         timestamp;
  } ev_t;

  function automatic logic signed [LEVEL_W-1:0] clamp_level(
    input logic signed [LEVEL_W-1:0] v,
    input logic signed [LEVEL_W-1:0] lim
  );
    logic signed [LEVEL_W-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

// ===== hdl/stpr_front.sv =====
// front stage: takes input beats, clamps set levels, registers the event
// depends on stpr_pkg
module stpr_front #(
  parameter int SAMPLE_BITS = stpr_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stpr_pkg::in_t     in_data,
  output logic              ev_valid,
  input  logic              ev_ready,
  output stpr_pkg::ev_t     ev_data
);

  localparam logic signed [stpr_pkg::LEVEL_W-1:0] MAX_LEVEL =
    stpr_pkg::LEVEL_W'((1 << (SAMPLE_BITS - 1)) - 1);

  assign in_ready = !ev_valid || ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
      if (in_valid) begin
        ev_data.toggle    <= (in_data.kind == stpr_pkg::KIND_TOGGLE);
        ev_data.level     <= stpr_pkg::clamp_level(in_data.level, MAX_LEVEL);
        ev_data.timestamp <= in_data.timestamp;
      end
    end
  end

endmodule

// ===== hdl/stpr_queue.sv =====
// short event queue between the front stage and the back engine
// depends on stpr_pkg for the event type
module stpr_queue #(
  parameter int DEPTH = stpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  stpr_pkg::ev_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output stpr_pkg::ev_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stpr_pkg::ev_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/stpr_back.sv =====
// back engine: span from elapsed ticks, boundary box filter, whole runs
// depends on stpr_pkg; holds the resampler state and the output register
module stpr_back #(
  parameter int FRAC_BITS   = stpr_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = stpr_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  stpr_pkg::cfg_t cfg,
  input  logic           ev_valid,
  output logic           ev_ready,
  input  stpr_pkg::ev_t  ev_data,
  output logic           out_valid,
  input  logic           out_ready,
  output stpr_pkg::out_t out_data
);

  localparam int LW     = stpr_pkg::LEVEL_W;
  localparam int TW     = stpr_pkg::TIME_W;
  localparam int RW     = stpr_pkg::RUN_W;
  localparam int SPAN_W = FRAC_BITS + RW;
  localparam int FULL_W = TW + FRAC_BITS;
  localparam int SUM_W  = FRAC_BITS + LW + 2;

  localparam logic [FRAC_BITS:0]   ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] FRAC_ONES = '1;
  localparam logic signed [LW-1:0] MAX_LEVEL = LW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SAMPLE_BITS-1:0] MAX_B   = MAX_LEVEL[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] MIN_B   =
    {1'b1, {(SAMPLE_BITS - 2){1'b0}}, 1'b1};
  localparam logic [SAMPLE_BITS-1:0] XMASK   = MAX_B ^ MIN_B;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SPAN, ST_PART, ST_MAC, ST_ACC, ST_BOUND, ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    ACC_ADD, ACC_BOUND, ACC_SET
  } acc_t;

  state_t                   state;
  acc_t                     mode;
  logic                     active;
  logic signed [LW-1:0]     held_level;
  logic [TW-1:0]            last_time;
  logic [FRAC_BITS:0]       plen;
  logic signed [SUM_W-1:0]  psum;
  logic [2*TW-1:0]          prod;
  logic [SPAN_W-1:0]        span;
  logic [FRAC_BITS:0]       weight;
  logic signed [LW-1:0]     val;
  logic [TW-1:0]            t_evt;
  logic signed [SUM_W-1:0]  mprod;

  logic [SAMPLE_BITS-1:0]        tog_bits;
  logic signed [SAMPLE_BITS-1:0] tog_s;
  logic signed [LW-1:0]          new_level;
  logic [TW-1:0]                 dt;
  logic [FULL_W-1:0]             span_full;
  logic [SPAN_W-1:0]             cap;
  logic [SPAN_W-1:0]             span_sat;
  logic [SPAN_W:0]               fill;
  logic                          over;
  logic [FRAC_BITS:0]            w_bound;
  logic                          more_run;
  logic [SUM_W-1:0]              psum_adj;
  logic [LW-1:0]                 sample_q;
  logic                          out_free;
  logic                          out_load;

  // toggle flips between the two extremes within SAMPLE_BITS
  assign tog_bits  = held_level[SAMPLE_BITS-1:0] ^ XMASK;
  assign tog_s     = $signed(tog_bits);
  assign new_level = ev_data.toggle ?
                     stpr_pkg::clamp_level(LW'(tog_s), MAX_LEVEL) : ev_data.level;
  assign dt        = ev_data.timestamp - last_time;

  assign span_full = prod[2*TW-1 -: FULL_W];
  assign cap       = {cfg.max_run, {FRAC_BITS{1'b0}}};
  assign span_sat  = (span_full > FULL_W'(cap)) ? cap : span_full[SPAN_W-1:0];

  assign fill      = (SPAN_W + 1)'(plen) + (SPAN_W + 1)'(span);
  assign over      = (fill > (SPAN_W + 1)'(ONE));
  assign w_bound   = ONE - plen;
  assign more_run  = (span > SPAN_W'(ONE));

  // divide by one sample, truncating toward zero
  assign psum_adj  = psum + (psum[SUM_W-1] ? SUM_W'(FRAC_ONES) : '0);
  assign sample_q  = psum_adj[FRAC_BITS +: LW];

  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == ST_BOUND) || (state == ST_RUN && more_run));
  assign ev_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= ACC_ADD;
      active     <= 1'b0;
      held_level <= -MAX_LEVEL;
      last_time  <= '0;
      plen       <= '0;
      psum       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (ev_valid) begin
            val   <= new_level;
            t_evt <= ev_data.timestamp;
            if (!active) begin
              // first event only records time and level
              active     <= 1'b1;
              last_time  <= ev_data.timestamp;
              held_level <= new_level;
              plen       <= '0;
              psum       <= '0;
            end else begin
              prod  <= (2*TW)'(dt) * (2*TW)'(cfg.samples_per_tick);
              state <= ST_SPAN;
            end
          end
        end
        ST_SPAN: begin
          span  <= span_sat;
          state <= ST_PART;
        end
        ST_PART: begin
          if (plen != '0 && over) begin
            weight <= w_bound;
            span   <= span - SPAN_W'(w_bound);
            mode   <= ACC_BOUND;
            state  <= ST_MAC;
          end else if (plen != '0) begin
            weight <= span[FRAC_BITS:0];
            mode   <= ACC_ADD;
            state  <= ST_MAC;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_MAC: begin
          mprod <= $signed(val) * $signed({1'b0, weight});
          state <= ST_ACC;
        end
        ST_ACC: begin
          unique case (mode)
            ACC_ADD: begin
              psum       <= psum + mprod;
              plen       <= plen + weight;
              last_time  <= t_evt;
              held_level <= val;
              state      <= ST_IDLE;
            end
            ACC_BOUND: begin
              psum  <= psum + mprod;
              state <= ST_BOUND;
            end
            ACC_SET: begin
              psum       <= mprod;
              plen       <= weight;
              last_time  <= t_evt;
              held_level <= val;
              state      <= ST_IDLE;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_BOUND: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{sample: sample_q, run_length: RW'(1), last: !more_run};
            psum      <= '0;
            plen      <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (more_run) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_data  <= '{sample: val, run_length: span[FRAC_BITS +: RW], last: 1'b1};
              weight    <= {1'b0, span[FRAC_BITS-1:0]};
              mode      <= ACC_SET;
              state     <= ST_MAC;
            end
          end else begin
            weight <= span[FRAC_BITS:0];
            mode   <= ACC_SET;
            state  <= ST_MAC;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= ONE)
    else $error("partial length exceeds one sample");

  a_first_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && ev_valid && !active) |=> (state == ST_IDLE && active))
    else $error("first event did not just record state");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.run_length != '0))
    else $error("result beat with zero run length");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sample <= MAX_LEVEL && out_data.sample >= -MAX_LEVEL))
    else $error("sample outside level range");
`endif

endmodule

// ===== hdl/speaker_toggle_pcm_resampler.sv =====
// Speaker toggle to PCM resampler, top level.
// Input channel (in_valid/in_ready/in_data): one beat per speaker event, either
// a set level or a toggle between the extremes, with its CPU tick timestamp.
// Output channel (out_valid/out_ready/out_data): beats of a PCM value and how
// many consecutive samples carry it; last marks the final beat of an event.
// An event yields zero, one or two beats: an optional box-filtered boundary
// sample with run length 1, then an optional run of whole samples.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready:
// index 0 is samples_per_tick (UQ0.32), index 1 is max_run; write it idle.
// Timing: the front register and the event queue each register an event on its way
// to the back engine. The engine only records the first event after reset; later
// ones pass its multiply, span clamp and multiply-accumulate steps and any emit
// steps, and it takes no new event until it is back to idle.
// Reset (rst, synchronous) empties the queue and output register, restores
// the config defaults and the minimum held level, and waits for a first event.
// When out_ready is low the engine holds at its emit step while the queue and
// front register keep taking events until they fill.
// Depends on stpr_pkg, stpr_front, stpr_queue and stpr_back.
module speaker_toggle_pcm_resampler #(
  parameter int FRAC_BITS   = stpr_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = stpr_pkg::SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = stpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stpr_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stpr_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  stpr_pkg::cfg_index_t           cfg_index,
  input  logic [stpr_pkg::RATIO_W-1:0]   cfg_data
);

  stpr_pkg::cfg_t cfg;
  logic           fe_valid;
  logic           fe_ready;
  stpr_pkg::ev_t  fe_data;
  logic           q_valid;
  logic           q_ready;
  stpr_pkg::ev_t  q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{samples_per_tick: stpr_pkg::SPT_RESET, max_run: stpr_pkg::MAX_RUN_RESET};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stpr_pkg::CFG_SAMPLES_PER_TICK: cfg.samples_per_tick <= cfg_data;
        stpr_pkg::CFG_MAX_RUN:          cfg.max_run <= cfg_data[stpr_pkg::RUN_W-1:0];
        default:                        cfg <= cfg;
      endcase
    end
  end

  stpr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ev_valid (fe_valid),
    .ev_ready (fe_ready),
    .ev_data  (fe_data)
  );

  stpr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  stpr_back #(
    .FRAC_BITS  (FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (q_valid),
    .ev_ready  (q_ready),
    .ev_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_top.sv =====
// testbench for speaker_toggle_pcm_resampler: directed and random speaker events,
// each pcm beat checked against an in-bench resampling predictor
// depends on stpr_pkg and the resampler rtl only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = stpr_pkg::FRAC_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam logic signed [stpr_pkg::LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
  localparam logic [stpr_pkg::LEVEL_W-1:0] TOGGLE_MASK = 16'h7FFF ^ 16'h8001;
  localparam logic [stpr_pkg::RATIO_W-1:0] RATIO_AT_RESET = 32'd189408058;
  localparam logic [stpr_pkg::RUN_W-1:0] RUN_CAP_AT_RESET = 16'd4096;
  // at this ratio one tick is exactly one fraction lsb of span
  localparam logic [stpr_pkg::RATIO_W-1:0] RATIO_UNIT = 32'd256;
  localparam logic [stpr_pkg::TIME_W-1:0] HALF = 32'h0080_0000;
  localparam logic [stpr_pkg::TIME_W-1:0] FULL = 32'h0100_0000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 272;
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  stpr_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  stpr_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  stpr_pkg::cfg_index_t cfg_index;
  logic [stpr_pkg::RATIO_W-1:0] cfg_data;

  // predictor state and register copies
  bit seen_first;
  logic signed [stpr_pkg::LEVEL_W-1:0] held;
  logic [stpr_pkg::TIME_W-1:0] held_time;
  longint unsigned frac_len;
  longint frac_acc;
  logic [stpr_pkg::RATIO_W-1:0] ratio_q;
  logic [stpr_pkg::RUN_W-1:0] run_cap;

  stpr_pkg::out_t pcm_due[$];
  logic [stpr_pkg::TIME_W-1:0] tick_now;
  bit in_busy;
  bit tx_idle_on;
  bit rx_idle_on;
  int fails;
  int events_sent;
  int beats_seen;
  int reg_writes;

  speaker_toggle_pcm_resampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic resample_event(input stpr_pkg::in_t item);
    logic signed [stpr_pkg::LEVEL_W-1:0] raw;
    logic signed [stpr_pkg::LEVEL_W-1:0] lvl;
    logic [stpr_pkg::TIME_W-1:0] dt;
    longint unsigned span;
    longint unsigned cap;
    longint unsigned w;
    stpr_pkg::out_t beats[$];
    stpr_pkg::out_t beat;
    bit merged;
    if (item.kind == stpr_pkg::KIND_TOGGLE) raw = held ^ TOGGLE_MASK;
    else raw = item.level;
    lvl = (raw < -LEVEL_MAX) ? -LEVEL_MAX : raw;
    if (!seen_first) begin
      seen_first = 1'b1;
      held = lvl;
      held_time = item.timestamp;
      frac_len = 0;
      frac_acc = 0;
      return;
    end
    dt = item.timestamp - held_time;
    span = (64'(dt) * 64'(ratio_q)) >> (stpr_pkg::RATIO_W - FRAC);
    cap = 64'(run_cap) << FRAC;
    if (span > cap) span = cap;
    merged = 1'b0;
    if (frac_len != 0) begin
      if (frac_len + span > ONE) begin
        // finish the boundary sample as a weighted average
        w = ONE - frac_len;
        frac_acc += longint'(lvl) * longint'(w);
        beat.sample = 16'(frac_acc / longint'(ONE));
        beat.run_length = 16'd1;
        beat.last = 1'b0;
        beats.push_back(beat);
        span -= w;
        frac_acc = 0;
        frac_len = 0;
      end else begin
        frac_acc += longint'(lvl) * longint'(span);
        frac_len += span;
        merged = 1'b1;
      end
    end
    if (!merged) begin
      if (span > ONE) begin
        beat.sample = lvl;
        beat.run_length = 16'(span >> FRAC);
        beat.last = 1'b0;
        beats.push_back(beat);
        span &= ONE - 1;
      end
      frac_acc = longint'(lvl) * longint'(span);
      frac_len = span;
    end
    held = lvl;
    held_time = item.timestamp;
    if (beats.size() != 0) beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) pcm_due.push_back(beats[i]);
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tick gaps scaled to the current ratio so spans land below, near and far above a sample
  function automatic logic [stpr_pkg::TIME_W-1:0] pick_ticks();
    longint unsigned per;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (ratio_q == 0 || r >= 92) return $urandom;
    per = 64'h1_0000_0000 / ratio_q;
    if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
    if (r < 10) return '0;
    if (r < 40) return $urandom_range(1, 32'(per));
    if (r < 75) return 32'(per * $urandom_range(1, 3) + $urandom_range(0, 32'(per)));
    return 32'(per * $urandom_range(4, 300));
  endfunction

  task automatic lower_input();
    if (in_busy) begin
      in_valid <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  task automatic send_event(input logic kind,
                            input logic signed [stpr_pkg::LEVEL_W-1:0] level,
                            input logic [stpr_pkg::TIME_W-1:0] ticks);
    stpr_pkg::in_t item;
    int unsigned gap;
    tick_now = tick_now + ticks;
    item.kind = kind;
    item.level = level;
    item.timestamp = tick_now;
    in_data <= item;
    in_valid <= 1'b1;
    in_busy = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    resample_event(item);
    events_sent++;
    gap = tx_idle_on ? pick_idle() : 0;
    if (gap != 0) begin
      lower_input();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input stpr_pkg::cfg_index_t idx,
                           input logic [stpr_pkg::RATIO_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      stpr_pkg::CFG_SAMPLES_PER_TICK: ratio_q = val;
      stpr_pkg::CFG_MAX_RUN: run_cap = val[stpr_pkg::RUN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // events that make no beat may still be in flight, so wait a while past the last beat
  task automatic settle();
    lower_input();
    while (pcm_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_first_event();
    send_event(stpr_pkg::KIND_SET, 16'sh8000, '0);
  endtask

  // reset values of both registers: a long gap saturates at the default max_run
  task automatic test_reset_config();
    send_event(stpr_pkg::KIND_SET, 16'sd1000, 32'd100000);
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, 32'd50);
    send_event(stpr_pkg::KIND_SET, -16'sd500, 32'd7);
  endtask

  task automatic test_exact_spans();
    settle();
    write_reg(stpr_pkg::CFG_SAMPLES_PER_TICK, RATIO_UNIT);
    write_reg(stpr_pkg::CFG_MAX_RUN, 32'd65535);
    // bring the partial sample back to zero
    send_event(stpr_pkg::KIND_SET, LEVEL_MAX, 32'(3 * ONE - frac_len));
    send_event(stpr_pkg::KIND_SET, -16'sd1, HALF);
    // negative half average truncates toward zero
    send_event(stpr_pkg::KIND_SET, 16'sd0, FULL);
    // partial fills exactly one sample and is kept
    send_event(stpr_pkg::KIND_SET, 16'sd100, HALF);
    // boundary sample with zero weight for the new level
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, 32'd1);
    send_event(stpr_pkg::KIND_SET, 16'sd32766, 32'(3 * ONE - 1));
    // toggle from 32766 lands on the most negative code and saturates
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, FULL);
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, '0);
    send_event(stpr_pkg::KIND_SET, 16'sh8000, 32'(2 * ONE));
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, FULL + HALF);
    send_event(stpr_pkg::KIND_SET, 16'sd0, 32'(ONE / 4));
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(stpr_pkg::CFG_MAX_RUN, 32'd1);
    send_event(stpr_pkg::KIND_SET, 16'sd5, 32'(10 * ONE));
    settle();
    write_reg(stpr_pkg::CFG_MAX_RUN, 32'd0);
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, 32'(5 * ONE));
    send_event(stpr_pkg::KIND_SET, -16'sd7, 32'(3 * ONE));
    settle();
    write_reg(stpr_pkg::CFG_SAMPLES_PER_TICK, 32'hFFFF_FFFF);
    write_reg(stpr_pkg::CFG_MAX_RUN, 32'd65535);
    send_event(stpr_pkg::KIND_TOGGLE, 16'sd0, 32'hFFFF_FFFF);
    settle();
    write_reg(stpr_pkg::CFG_SAMPLES_PER_TICK, 32'd0);
    send_event(stpr_pkg::KIND_SET, 16'sd1234, 32'h8000_0000);
  endtask

  task automatic test_random();
    logic [stpr_pkg::RATIO_W-1:0] ratio;
    logic [stpr_pkg::RUN_W-1:0] cap;
    logic kind;
    logic signed [stpr_pkg::LEVEL_W-1:0] level;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          ratio = RATIO_AT_RESET;
          cap = RUN_CAP_AT_RESET;
        end
        1: begin
          ratio = 32'h0100_0000;
          cap = 16'd3;
        end
        2: begin
          ratio = 32'hFFFF_FFFF;
          cap = 16'd65535;
        end
        3: begin
          ratio = $urandom;
          cap = 16'($urandom_range(1, 65535));
        end
        4: begin
          ratio = $urandom_range(1, 32'h0010_0000);
          cap = 16'($urandom_range(1, 64));
        end
        default: begin
          ratio = $urandom;
          cap = 16'd1;
        end
      endcase
      settle();
      write_reg(stpr_pkg::CFG_SAMPLES_PER_TICK, ratio);
      write_reg(stpr_pkg::CFG_MAX_RUN, 32'(cap));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 64 == 0) begin
          tx_idle_on = ($urandom_range(0, 3) != 0);
          rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        // sender holds off until the output side has drained
        if (i == ITEMS_PER_PHASE / 2) begin
          lower_input();
          do @(posedge clk); while (pcm_due.size() != 0);
        end
        kind = ($urandom_range(0, 99) < 35) ? stpr_pkg::KIND_TOGGLE : stpr_pkg::KIND_SET;
        case ($urandom_range(0, 9))
          0: level = LEVEL_MAX;
          1: level = -LEVEL_MAX;
          2: level = 16'sh8000;
          3: level = '0;
          default: level = 16'($urandom);
        endcase
        send_event(kind, level, pick_ticks());
      end
    end
  endtask

  always @(posedge clk) begin : pcm_check
    stpr_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pcm_due.size() == 0) begin
        $error("unexpected pcm beat: sample %0d run_length %0d last %0b",
               out_data.sample, out_data.run_length, out_data.last);
        fails++;
      end else begin
        want = pcm_due.pop_front();
        beats_seen++;
        if (out_data.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
          fails++;
        end
        if (out_data.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, out_data.run_length);
          fails++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fails++;
        end
      end
    end
  end

  initial begin : pcm_sink
    int unsigned n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = rx_idle_on ? pick_idle() : 0;
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_tests
    int guard;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= stpr_pkg::CFG_SAMPLES_PER_TICK;
    cfg_data <= '0;
    seen_first = 1'b0;
    held = -LEVEL_MAX;
    held_time = '0;
    frac_len = 0;
    frac_acc = 0;
    ratio_q = RATIO_AT_RESET;
    run_cap = RUN_CAP_AT_RESET;
    tick_now = 32'hFFFF_FF00;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_first_event();
    test_reset_config();
    test_exact_spans();
    test_register_extremes();
    test_random();

    lower_input();
    guard = 0;
    while (pcm_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pcm_due.size() != 0) begin
      $error("%0d pcm beats never arrived", pcm_due.size());
      fails += pcm_due.size();
    end

    $display("resampler run: %0d speaker events, %0d pcm beats checked, %0d register writes",
             events_sent, beats_seen, reg_writes);
    $display("covered set and toggle events, partial and whole-sample spans, ratio and run caps");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
